[sv/psp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psp_pkg
// Shared types, constants and arithmetic helpers of the scan path generator.
// ----------------------------------------------------------------------------
package psp_pkg;

    localparam int ANGLE_BITS  = 16;
    localparam int TRIG_STAGES = 16;
    localparam int LAT_SHIFT   = 48 - ANGLE_BITS;
    localparam int LATENCY     = 2 * TRIG_STAGES + 10;

    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

    localparam logic [2:0] MODE_EQUATOR = 3'd0;
    localparam logic [2:0] MODE_POLAR   = 3'd1;
    localparam logic [2:0] MODE_HELIX   = 3'd2;
    localparam logic [2:0] MODE_VOSC    = 3'd3;
    localparam logic [2:0] MODE_LAT     = 3'd4;

    localparam logic [3:0] REG_PATH_MODE  = 4'd0;
    localparam logic [3:0] REG_CENTER_X   = 4'd1;
    localparam logic [3:0] REG_CENTER_Y   = 4'd2;
    localparam logic [3:0] REG_CENTER_Z   = 4'd3;
    localparam logic [3:0] REG_RADIUS     = 4'd4;
    localparam logic [3:0] REG_AMPLITUDE  = 4'd5;
    localparam logic [3:0] REG_CYCLES     = 4'd6;
    localparam logic [3:0] REG_NODE_ANGLE = 4'd7;

    typedef struct packed {
        logic [16:0]           t;
        logic [ANGLE_BITS-1:0] th;
        logic [ANGLE_BITS-1:0] m;
    } item_t;

    typedef struct packed {
        logic [2:0]         path_mode;
        logic signed [31:0] center_x;
        logic signed [31:0] center_y;
        logic signed [31:0] center_z;
        logic [30:0]        radius;
        logic signed [31:0] amplitude;
        logic [15:0]        node_angle;
    } cfg_t;

    function automatic logic [31:0] atan_turn(input int i);
        logic [31:0] v;
        case (i)
            0:  v = 32'h20000000;
            1:  v = 32'h12E4051E;
            2:  v = 32'h09FB385B;
            3:  v = 32'h051111D4;
            4:  v = 32'h028B0D43;
            5:  v = 32'h0145D7E1;
            6:  v = 32'h00A2F61E;
            7:  v = 32'h00517C55;
            8:  v = 32'h0028BE53;
            9:  v = 32'h00145F2F;
            10: v = 32'h000A2F98;
            11: v = 32'h000517CC;
            12: v = 32'h00028BE6;
            13: v = 32'h000145F3;
            14: v = 32'h0000A2FA;
            15: v = 32'h0000517D;
            16: v = 32'h000028BE;
            17: v = 32'h0000145F;
            18: v = 32'h00000A30;
            19: v = 32'h00000518;
            20: v = 32'h0000028C;
            21: v = 32'h00000146;
            22: v = 32'h000000A3;
            23: v = 32'h00000051;
            default: v = 32'h0;
        endcase
        return v;
    endfunction

    // q9.16 value to turn phase, truncated and wrapped
    function automatic logic [ANGLE_BITS-1:0] phase_of(input logic [24:0] f);
        logic [47:0] w;
        w = {23'b0, f};
        if (ANGLE_BITS >= 16)
            w = w << (ANGLE_BITS - 16);
        else
            w = w >> (16 - ANGLE_BITS);
        return w[ANGLE_BITS-1:0];
    endfunction

    // q17.16 times q2.30, rounded
    function automatic logic signed [33:0] mulq(input logic signed [32:0] a,
                                                 input logic signed [31:0] q);
        logic signed [65:0] p;
        p = a * q + (66'sd1 <<< 29);
        return $signed(p[63:30]);
    endfunction

    function automatic logic [31:0] sat32(input logic signed [34:0] v);
        logic [31:0] r;
        if (v > 35'sd2147483647)
            r = 32'h7FFFFFFF;
        else if (v < -35'sd2147483648)
            r = 32'h80000000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

[sv/psp_cordic.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psp_cordic
// Pipelined rotation cordic: turn phase in, q2.30 cosine and sine out.
// ----------------------------------------------------------------------------
module psp_cordic (
    input  logic                            clk,
    input  logic [psp_pkg::ANGLE_BITS-1:0]  phase,
    output logic signed [31:0]              cos_q,
    output logic signed [31:0]              sin_q
);
    import psp_pkg::*;

    logic signed [33:0] x_reg [0:TRIG_STAGES];
    logic signed [33:0] y_reg [0:TRIG_STAGES];
    logic signed [33:0] z_reg [0:TRIG_STAGES];
    logic               flip_reg [0:TRIG_STAGES];
    logic signed [31:0] cos_reg;
    logic signed [31:0] sin_reg;

    logic [31:0] a32;
    logic [31:0] a_sum;
    logic        flip;
    logic [31:0] a_fold;

    // fold into [-1/4, 1/4) turn by a half turn
    always_comb
    begin
        a32    = {phase, {(32 - ANGLE_BITS){1'b0}}};
        a_sum  = a32 + 32'h40000000;
        flip   = a_sum[31];
        a_fold = {a32[31] ^ flip, a32[30:0]};
    end

    always_ff @(posedge clk)
    begin
        x_reg[0]    <= CORDIC_GAIN;
        y_reg[0]    <= '0;
        z_reg[0]    <= {{2{a_fold[31]}}, a_fold};
        flip_reg[0] <= flip;
        for (int k = 0; k < TRIG_STAGES; k++)
        begin
            if (!z_reg[k][33])
            begin
                x_reg[k+1] <= x_reg[k] - (y_reg[k] >>> k);
                y_reg[k+1] <= y_reg[k] + (x_reg[k] >>> k);
                z_reg[k+1] <= z_reg[k] - $signed({2'b0, atan_turn(k)});
            end
            else
            begin
                x_reg[k+1] <= x_reg[k] + (y_reg[k] >>> k);
                y_reg[k+1] <= y_reg[k] - (x_reg[k] >>> k);
                z_reg[k+1] <= z_reg[k] + $signed({2'b0, atan_turn(k)});
            end
            flip_reg[k+1] <= flip_reg[k];
        end
        cos_reg <= flip_reg[TRIG_STAGES] ? 32'(-x_reg[TRIG_STAGES])
                                         : 32'(x_reg[TRIG_STAGES]);
        sin_reg <= flip_reg[TRIG_STAGES] ? 32'(-y_reg[TRIG_STAGES])
                                         : 32'(y_reg[TRIG_STAGES]);
    end

    assign cos_q = cos_reg;
    assign sin_q = sin_reg;

endmodule

[sv/psp_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psp_front
// Accepts requests and works out the path and oscillation phases.
// ----------------------------------------------------------------------------
module psp_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [16:0]     t,
    input  logic [7:0]      cycles,
    input  logic            q_full,
    output logic            busy,
    output logic            push,
    output psp_pkg::item_t  item
);
    import psp_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  accept;
    logic [24:0] tn;

    assign busy   = valid_reg && q_full;
    assign accept = start && !busy;
    assign push   = valid_reg && !q_full;
    assign tn     = t * cycles;

    always_comb
    begin
        if (accept)
            valid_next = 1'b1;
        else if (q_full)
            valid_next = valid_reg;
        else
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.t  <= t;
            item_reg.th <= phase_of({8'b0, t});
            item_reg.m  <= phase_of(tn);
        end
    end

    assign item = item_reg;

endmodule

[sv/psp_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psp_queue
// Two-entry queue between the front and the back pipeline.
// ----------------------------------------------------------------------------
module psp_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  psp_pkg::item_t  push_item,
    input  logic            pop,
    output logic            full,
    output logic            valid,
    output psp_pkg::item_t  head
);
    import psp_pkg::*;

    item_t      mem [0:1];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_pop;

    assign full   = (count_reg == 2'd2);
    assign valid  = (count_reg != 2'd0);
    assign head   = mem[rd_ptr_reg];
    assign do_pop = pop && valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (push && !do_pop)
                count_reg <= count_reg + 2'd1;
            else if (do_pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_item;
    end

endmodule

[sv/psp_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psp_back
// Trig, scaling and centre offset pipeline; one point per clock.
// ----------------------------------------------------------------------------
module psp_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  psp_pkg::item_t      in_item,
    input  psp_pkg::cfg_t       cfg,
    output logic                done,
    output logic signed [31:0]  pos_x,
    output logic signed [31:0]  pos_y,
    output logic signed [31:0]  pos_z
);
    import psp_pkg::*;

    localparam int L1 = TRIG_STAGES + 2;
    localparam int L2 = TRIG_STAGES + 3;

    typedef struct packed {
        logic [16:0]        t;
        logic signed [31:0] ct;
        logic signed [31:0] st;
        logic signed [31:0] cm;
        logic signed [31:0] sm;
        logic signed [31:0] cn;
        logic signed [31:0] sn;
    } trig_t;

    logic signed [31:0] ct, st, cm, sm, cn, sn, cl, sl;

    logic [16:0] t1_reg [0:L1-1];
    logic        v1_reg [0:L1-1];
    trig_t       d2_reg [0:L2-1];
    logic        v2_reg [0:L2-1];
    trig_t       tap1;
    trig_t       tap2;

    logic signed [63:0]    lat_prod_reg;
    logic signed [64:0]    lat_sum;
    logic [ANGLE_BITS-1:0] lat_phase;

    logic signed [32:0] r33;
    logic signed [32:0] h33;
    logic signed [17:0] tc;
    logic signed [49:0] hprod;
    logic is_polar, is_helix, is_vosc, is_lat;

    logic               v3_reg, v4_reg, done_reg;
    logic               mix_reg;
    logic signed [32:0] w_reg;
    logic signed [31:0] c2_reg, s2_reg;
    logic signed [33:0] ox0_reg, oy0_reg, oz3_reg;
    logic signed [33:0] ox4_reg, oy4_reg, oz4_reg;
    logic signed [33:0] oz_sel;
    logic signed [33:0] w_full;
    logic [31:0]        px_reg, py_reg, pz_reg;

    psp_cordic u_cordic_th (.clk(clk), .phase(in_item.th), .cos_q(ct), .sin_q(st));
    psp_cordic u_cordic_m  (.clk(clk), .phase(in_item.m),  .cos_q(cm), .sin_q(sm));
    psp_cordic u_cordic_nd (.clk(clk), .phase(phase_of({9'b0, cfg.node_angle})),
                            .cos_q(cn), .sin_q(sn));
    psp_cordic u_cordic_l  (.clk(clk), .phase(lat_phase), .cos_q(cl), .sin_q(sl));

    always_comb
    begin
        tap1.t  = t1_reg[L1-1];
        tap1.ct = ct;
        tap1.st = st;
        tap1.cm = cm;
        tap1.sm = sm;
        tap1.cn = cn;
        tap1.sn = sn;
        tap2    = d2_reg[L2-1];
    end

    // valid bits along the delay lines
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < L1; k++)
                v1_reg[k] <= 1'b0;
            for (int k = 0; k < L2; k++)
                v2_reg[k] <= 1'b0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg[0] <= in_valid;
            for (int k = 1; k < L1; k++)
                v1_reg[k] <= v1_reg[k-1];
            v2_reg[0] <= v1_reg[L1-1];
            for (int k = 1; k < L2; k++)
                v2_reg[k] <= v2_reg[k-1];
            v3_reg   <= v2_reg[L2-1];
            v4_reg   <= v3_reg;
            done_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        t1_reg[0] <= in_item.t;
        for (int k = 1; k < L1; k++)
            t1_reg[k] <= t1_reg[k-1];
        d2_reg[0] <= tap1;
        for (int k = 1; k < L2; k++)
            d2_reg[k] <= d2_reg[k-1];
        lat_prod_reg <= tap1.sm * cfg.amplitude;
    end

    // latitude: quarter turn times s(m) * a, rounded
    always_comb
    begin
        lat_sum   = {lat_prod_reg[63], lat_prod_reg} + (65'sd1 <<< (LAT_SHIFT - 1));
        lat_phase = lat_sum[47 -: ANGLE_BITS];
    end

    always_comb
    begin
        is_polar = (cfg.path_mode == MODE_POLAR);
        is_helix = (cfg.path_mode == MODE_HELIX);
        is_vosc  = (cfg.path_mode == MODE_VOSC);
        is_lat   = (cfg.path_mode == MODE_LAT);
        r33      = $signed({2'b0, cfg.radius});
        h33      = {cfg.amplitude[31], cfg.amplitude};
        tc       = $signed({1'b0, tap2.t}) - 18'sd32768;
        hprod    = cfg.amplitude * tc + (50'sd1 <<< 15);
        w_full   = mulq(r33, is_lat ? cl : tap2.ct);
        if (is_polar)
            oz_sel = mulq(r33, tap2.st);
        else if (is_lat)
            oz_sel = mulq(r33, sl);
        else if (is_helix)
            oz_sel = $signed(hprod[49:16]);
        else if (is_vosc)
            oz_sel = mulq(h33, tap2.sm);
        else
            oz_sel = '0;
    end

    always_ff @(posedge clk)
    begin
        w_reg   <= w_full[32:0];
        c2_reg  <= is_polar ? tap2.cn : tap2.ct;
        s2_reg  <= is_polar ? tap2.sn : tap2.st;
        mix_reg <= is_polar || is_lat;
        ox0_reg <= mulq(r33, is_helix ? tap2.cm : tap2.ct);
        oy0_reg <= mulq(r33, is_helix ? tap2.sm : tap2.st);
        oz3_reg <= oz_sel;

        ox4_reg <= mix_reg ? mulq(w_reg, c2_reg) : ox0_reg;
        oy4_reg <= mix_reg ? mulq(w_reg, s2_reg) : oy0_reg;
        oz4_reg <= oz3_reg;

        px_reg <= sat32({{3{cfg.center_x[31]}}, cfg.center_x} + {ox4_reg[33], ox4_reg});
        py_reg <= sat32({{3{cfg.center_y[31]}}, cfg.center_y} + {oy4_reg[33], oy4_reg});
        pz_reg <= sat32({{3{cfg.center_z[31]}}, cfg.center_z} + {oz4_reg[33], oz4_reg});
    end

    assign done  = done_reg;
    assign pos_x = $signed(px_reg);
    assign pos_y = $signed(py_reg);
    assign pos_z = $signed(pz_reg);

endmodule

[sv/parametric_scan_path_point.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// parametric_scan_path_point
// Scan path point generator: path parameter in, 3d q16.16 point out.
// ----------------------------------------------------------------------------
// usage
//   request: drive t and raise start; it is taken on a clock edge where busy
//   is low. one request can be taken every clock.
//   result: done is high for one cycle with pos_x, pos_y, pos_z valid; the
//   receiver has no way to stall, so results leave as they are produced.
//   result path: the point is worked out by two cordic passes in series
//   (oscillation angle, then latitude angle).
//   throughput: one point per clock, every unit is fully pipelined.
//   config: cfg_we writes cfg_wdata into register cfg_addr (0 mode, 1-3
//   centre, 4 radius, 5 amplitude, 6 oscillations, 7 node angle); other indexes
//   are dropped. write only while no requests are in flight.
//   reset: rst_n clears the pipeline and loads the default registers
//   (equatorial, origin, unit radius, one oscillation).
// ----------------------------------------------------------------------------
module parametric_scan_path_point (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [16:0]         t,
    output logic                done,
    output logic signed [31:0]  pos_x,
    output logic signed [31:0]  pos_y,
    output logic signed [31:0]  pos_z,
    input  logic                cfg_we,
    input  logic [3:0]          cfg_addr,
    input  logic [31:0]         cfg_wdata
);
    import psp_pkg::*;

    cfg_t       cfg_reg;
    logic [7:0] cycles_reg;

    logic  push;
    item_t push_item;
    logic  q_full;
    logic  q_valid;
    item_t q_head;

    // configuration register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.path_mode  <= MODE_EQUATOR;
            cfg_reg.center_x   <= '0;
            cfg_reg.center_y   <= '0;
            cfg_reg.center_z   <= '0;
            cfg_reg.radius     <= 31'd65536;
            cfg_reg.amplitude  <= '0;
            cfg_reg.node_angle <= '0;
            cycles_reg         <= 8'd1;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_PATH_MODE:  cfg_reg.path_mode  <= cfg_wdata[2:0];
                REG_CENTER_X:   cfg_reg.center_x   <= $signed(cfg_wdata);
                REG_CENTER_Y:   cfg_reg.center_y   <= $signed(cfg_wdata);
                REG_CENTER_Z:   cfg_reg.center_z   <= $signed(cfg_wdata);
                REG_RADIUS:     cfg_reg.radius     <= cfg_wdata[30:0];
                REG_AMPLITUDE:  cfg_reg.amplitude  <= $signed(cfg_wdata);
                REG_CYCLES:     cycles_reg         <= cfg_wdata[7:0];
                REG_NODE_ANGLE: cfg_reg.node_angle <= cfg_wdata[15:0];
                default:        ;
            endcase
        end
    end

    // front: takes the request, works out both phases
    psp_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .t      (t),
        .cycles (cycles_reg),
        .q_full (q_full),
        .busy   (busy),
        .push   (push),
        .item   (push_item)
    );

    // short queue decoupling the two halves
    psp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (1'b1),
        .full      (q_full),
        .valid     (q_valid),
        .head      (q_head)
    );

    // back: trig, scaling, centre offset and saturation
    psp_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (q_valid),
        .in_item  (q_head),
        .cfg      (cfg_reg),
        .done     (done),
        .pos_x    (pos_x),
        .pos_y    (pos_y),
        .pos_z    (pos_z)
    );

endmodule

[sv/psp_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psp_checker
// Port level checks of request to result timing and of front stalls.
// ----------------------------------------------------------------------------
module psp_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done
);
    import psp_pkg::*;

    logic accept;
    assign accept = start && !busy;

    // every request yields a result after the fixed latency
    a_req_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##LATENCY done)
        else $error("request without result");

    // no result appears without a matching request
    a_done_has_req: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, LATENCY))
        else $error("result without request");

    // the back drains one request a clock, so the front never stalls
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("front stalled");

endmodule

bind parametric_scan_path_point psp_checker u_psp_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done)
);
